FILE: hw/rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// shared constants and types of the 3x3 box blur: image geometry, arithmetic
// widths, reciprocal for the divide by nine and the queued item descriptor
// ----------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

  localparam int ImageSize = 128;
  localparam int CoordW    = $clog2(ImageSize);
  localparam logic [CoordW-1:0] LastIdx = CoordW'(ImageSize - 1);

  localparam int PixW = 8;
  localparam logic [PixW-1:0] BorderVal = PixW'(255);
  localparam int ColW = $clog2(3 * 255 + 1);
  localparam int SumW = $clog2(9 * 255 + 1);

  // floor(s / 9) == (s * RecipMul) >> RecipShift for every window sum
  localparam int RecipShift = 16;
  localparam int RecipMul   = (1 << RecipShift) / 9 + 1;
  localparam int RecipW     = $clog2(RecipMul + 1);
  localparam int ProdW      = SumW + RecipW;

  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // result kinds one input item can cause
  localparam int KindA    = 0;  // the pixel the window is centred on
  localparam int KindB    = 1;  // right border pixel of the row above
  localparam int KindC    = 2;  // bottom border pixel under the input
  localparam int NumKinds = 3;

  typedef struct packed {
    logic [CoordW-1:0]   col;
    logic [CoordW-1:0]   row;
    logic [PixW-1:0]     avg;
    logic [NumKinds-1:0] kinds;
  } item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bb3_ram.sv
// ----------------------------------------------------------------------------
// bb3_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bb3_front.sv
// ----------------------------------------------------------------------------
// bb3_front
// accepts pixels, keeps the raster counters and both line buffers, forms the
// window sum and the divide by nine, and classifies the results of each item
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [bb3_pkg::PixW-1:0]    pixel_red_i,
  output logic                             in_stall_o,
  input  wire logic [bb3_pkg::QCntW-1:0]   q_count_i,
  output logic                             push_o,
  output bb3_pkg::item_t                   item_o
);

  localparam int OccW = bb3_pkg::QCntW + 1;

  logic                          accept;
  logic [OccW-1:0]               occupancy;
  logic [bb3_pkg::CoordW-1:0]    col_q, col_d, row_q, row_d;

  logic                          s1_v_q;
  logic [bb3_pkg::PixW-1:0]      s1_px_q;
  logic [bb3_pkg::CoordW-1:0]    s1_col_q, s1_row_q;

  logic [2*bb3_pkg::PixW-1:0]    rd_data;
  logic [bb3_pkg::PixW-1:0]      top, mid;
  logic [bb3_pkg::ColW-1:0]      col_sum;
  logic [bb3_pkg::ColW-1:0]      cs_q [2];
  logic [bb3_pkg::SumW-1:0]      win_sum;
  logic [bb3_pkg::NumKinds-1:0]  kinds;
  logic                          inner;

  logic                          s2_v_q, s2_v_d;
  logic [bb3_pkg::SumW-1:0]      s2_sum_q;
  logic [bb3_pkg::CoordW-1:0]    s2_col_q, s2_row_q;
  logic [bb3_pkg::NumKinds-1:0]  s2_kinds_q;
  logic                          s2_inner_q;

  logic [bb3_pkg::ProdW-1:0]     prod;
  logic [bb3_pkg::PixW-1:0]      quot;

  // room in the queue for every item still in the pipe
  assign occupancy  = OccW'(q_count_i) + OccW'(s1_v_q) + OccW'(s2_v_q);
  assign in_stall_o = occupancy >= OccW'(bb3_pkg::QueueDepth);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_q == bb3_pkg::LastIdx) begin
        col_d = '0;
        row_d = (row_q == bb3_pkg::LastIdx) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // line buffers: high byte two rows up, low byte one row up
  bb3_ram #(
    .Width (2 * bb3_pkg::PixW),
    .Depth (bb3_pkg::ImageSize)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (s1_v_q),
    .waddr_i (s1_col_q),
    .wdata_i ({mid, s1_px_q}),
    .raddr_i (col_q),
    .rdata_o (rd_data)
  );

  assign top     = rd_data[2*bb3_pkg::PixW-1:bb3_pkg::PixW];
  assign mid     = rd_data[bb3_pkg::PixW-1:0];
  assign col_sum = bb3_pkg::ColW'(top) + bb3_pkg::ColW'(mid) + bb3_pkg::ColW'(s1_px_q);
  assign win_sum = bb3_pkg::SumW'(cs_q[0]) + bb3_pkg::SumW'(cs_q[1])
                 + bb3_pkg::SumW'(col_sum);

  always_comb begin
    kinds                   = '0;
    kinds[bb3_pkg::KindA]   = (s1_row_q == '0) || (s1_col_q != '0);
    kinds[bb3_pkg::KindB]   = (s1_row_q != '0) && (s1_col_q == bb3_pkg::LastIdx);
    kinds[bb3_pkg::KindC]   = (s1_row_q == bb3_pkg::LastIdx);
    inner = (s1_col_q >= bb3_pkg::CoordW'(2)) && (s1_row_q >= bb3_pkg::CoordW'(2));
  end

  assign s2_v_d = s1_v_q && (kinds != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      s1_v_q <= accept;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q  <= pixel_red_i;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
    end
    if (s1_v_q) begin
      cs_q[0]    <= cs_q[1];
      cs_q[1]    <= col_sum;
      s2_sum_q   <= win_sum;
      s2_col_q   <= s1_col_q;
      s2_row_q   <= s1_row_q;
      s2_kinds_q <= kinds;
      s2_inner_q <= inner;
    end
  end

  assign prod = bb3_pkg::ProdW'(s2_sum_q) * bb3_pkg::ProdW'(bb3_pkg::RecipMul);
  assign quot = prod[bb3_pkg::RecipShift +: bb3_pkg::PixW];

  assign push_o       = s2_v_q;
  assign item_o.col   = s2_col_q;
  assign item_o.row   = s2_row_q;
  assign item_o.avg   = s2_inner_q ? quot : bb3_pkg::BorderVal;
  assign item_o.kinds = s2_kinds_q;

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> q_count_i != bb3_pkg::QCntW'(bb3_pkg::QueueDepth))
    else $error("push into a full queue");

  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count_i == bb3_pkg::QCntW'(bb3_pkg::QueueDepth)) |-> in_stall_o)
    else $error("input taken with a full queue");

endmodule

`default_nettype wire

FILE: hw/rtl/bb3_queue.sv
// ----------------------------------------------------------------------------
// bb3_queue
// short item queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_queue (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire bb3_pkg::item_t             item_i,
  input  wire logic                       pop_i,
  output bb3_pkg::item_t                  head_o,
  output logic [bb3_pkg::QCntW-1:0]       count_o
);

  bb3_pkg::item_t                 entries_q [bb3_pkg::QueueDepth];
  logic [bb3_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [bb3_pkg::QCntW-1:0]      count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

  assign head_o  = entries_q[rd_ptr_q];
  assign count_o = count_q;

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from an empty queue");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bb3_pkg::QPtrW'(count_q) == bb3_pkg::QPtrW'(wr_ptr_q - rd_ptr_q))
    else $error("queue pointers and count disagree");

endmodule

`default_nettype wire

FILE: hw/rtl/bb3_back.sv
// ----------------------------------------------------------------------------
// bb3_back
// expands each queued item into its results, one a cycle unless the output
// stalls, into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bb3_pkg::item_t               head_i,
  input  wire logic [bb3_pkg::QCntW-1:0]    count_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [bb3_pkg::CoordW-1:0]        out_x_o,
  output logic [bb3_pkg::CoordW-1:0]        out_y_o,
  output logic [bb3_pkg::PixW-1:0]          value_o,
  output logic                              last_of_item_o,
  output logic                              last_of_frame_o
);

  logic                          load, has_item;
  logic [bb3_pkg::NumKinds-1:0]  done_q, done_d, pend, sel, rest;
  logic                          out_valid_q, out_valid_d;
  logic [bb3_pkg::CoordW-1:0]    x_q, x_d, y_q, y_d;
  logic [bb3_pkg::PixW-1:0]      val_q, val_d;
  logic                          loi_q, lof_q, lof_d;

  assign has_item = count_i != '0;
  assign load     = has_item && (!out_valid_q || !out_stall_i);
  assign pend     = head_i.kinds & ~done_q;
  assign rest     = pend & ~sel;
  assign pop_o    = load && (rest == '0);

  always_comb begin
    sel   = '0;
    x_d   = head_i.col;
    y_d   = bb3_pkg::LastIdx;
    val_d = bb3_pkg::BorderVal;
    lof_d = 1'b0;
    if (pend[bb3_pkg::KindA]) begin
      sel[bb3_pkg::KindA] = 1'b1;
      val_d = head_i.avg;
      if (head_i.row == '0) begin
        y_d = '0;
      end else begin
        x_d = head_i.col - 1'b1;
        y_d = head_i.row - 1'b1;
      end
    end else if (pend[bb3_pkg::KindB]) begin
      sel[bb3_pkg::KindB] = 1'b1;
      x_d = bb3_pkg::LastIdx;
      y_d = head_i.row - 1'b1;
    end else begin
      sel[bb3_pkg::KindC] = 1'b1;
      lof_d = head_i.col == bb3_pkg::LastIdx;
    end
  end

  always_comb begin
    done_d = done_q;
    if (load) begin
      done_d = pop_o ? '0 : (done_q | sel);
    end
  end

  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q   <= x_d;
      y_q   <= y_d;
      val_q <= val_d;
      loi_q <= rest == '0;
      lof_q <= lof_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_x_o         = x_q;
  assign out_y_o         = y_q;
  assign value_o         = val_q;
  assign last_of_item_o  = loi_q;
  assign last_of_frame_o = lof_q;

  a_head_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_item |-> pend != '0)
    else $error("queued item with no result left");

  a_frame_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && lof_q) |-> loi_q)
    else $error("frame end not on the last result of its item");

endmodule

`default_nettype wire

FILE: hw/rtl/box_blur_3x3_raster_unit.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_raster_unit
// 3x3 box blur over a square grey image fed as red bytes in raster order
//
// input channel: one red byte per item (in_valid_i / in_stall_o), pixels of
// a 128 x 128 frame in raster order, frames back to back.
// output channel: one blurred pixel per item (out_valid_o / out_stall_i)
// with its column, row, value (255 on the border), last_of_item_o on the
// final result of an input pixel and last_of_frame_o on the bottom right one.
// row 0 goes out as it arrives; row r goes out while row r+1 arrives, the
// bottom row alongside the tail of the row above it.
// throughput: one pixel per cycle when not stalled; in the bottom row each extra
// result holds the input back, while the extra result at the end of a middle row
// fills the slot of the next row's first pixel, which causes none.
// the result pipe is the line buffer read, the window add, the reciprocal
// multiply and a 4-entry item queue in front of the output register.
// reset clears counters, pipe and queue; line buffers need no clearing.
// a stalled output holds its result; in_stall_o rises once queue and pipe fill.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_raster_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [bb3_pkg::PixW-1:0]    pixel_red_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [bb3_pkg::CoordW-1:0]       out_x_o,
  output logic [bb3_pkg::CoordW-1:0]       out_y_o,
  output logic [bb3_pkg::PixW-1:0]         value_o,
  output logic                             last_of_item_o,
  output logic                             last_of_frame_o
);

  logic                          push, pop;
  bb3_pkg::item_t                push_item, head_item;
  logic [bb3_pkg::QCntW-1:0]     q_count;

  bb3_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .pixel_red_i (pixel_red_i),
    .in_stall_o  (in_stall_o),
    .q_count_i   (q_count),
    .push_o      (push),
    .item_o      (push_item)
  );

  bb3_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .head_o  (head_item),
    .count_o (q_count)
  );

  bb3_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_item),
    .count_i         (q_count),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_x_o         (out_x_o),
    .out_y_o         (out_y_o),
    .value_o         (value_o),
    .last_of_item_o  (last_of_item_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

`default_nettype wire
